// ----- rtl/calendar_time_field_editor_core_macros.svh -----
// Assertion macros used by the checker of the calendar time field editor.
`ifndef CALENDAR_TIME_FIELD_EDITOR_CORE_MACROS_SVH
`define CALENDAR_TIME_FIELD_EDITOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define CTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define CTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cte_pkg.sv -----
// Types, codes and constants of the calendar time field editor.
`timescale 1ns / 1ps

package cte_pkg;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_COMMIT = 3'd2;
  localparam logic [2:0] CMD_NEXT   = 3'd3;
  localparam logic [2:0] CMD_PREV   = 3'd4;
  localparam logic [2:0] CMD_INC    = 3'd5;
  localparam logic [2:0] CMD_DEC    = 3'd6;

  localparam logic [2:0] FIELD_WEEKDAY = 3'd0;
  localparam logic [2:0] FIELD_MONTH   = 3'd1;
  localparam logic [2:0] FIELD_DATE    = 3'd2;
  localparam logic [2:0] FIELD_YEAR    = 3'd3;
  localparam logic [2:0] FIELD_HOUR    = 3'd4;
  localparam logic [2:0] FIELD_MINUTE  = 3'd5;
  localparam logic [2:0] FIELD_SECOND  = 3'd6;

  localparam logic [2:0]  WEEKDAY_MIN = 3'd1;
  localparam logic [2:0]  WEEKDAY_MAX = 3'd7;
  localparam logic [3:0]  MONTH_MIN   = 4'd1;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [4:0]  DATE_MIN    = 5'd1;
  localparam logic [11:0] YEAR_MIN    = 12'd1900;
  localparam logic [11:0] YEAR_MAX    = 12'd2099;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [5:0]  MINSEC_MAX  = 6'd59;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [4:0]  date;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cte_time_t;

  typedef struct packed {
    logic commit;
    logic cancel;
  } cte_flags_t;

  localparam cte_time_t RESET_TIME = '{
    weekday: WEEKDAY_MIN, month: MONTH_MIN, date: DATE_MIN, year: YEAR_MIN,
    hour: 5'd0, minute: 6'd0, second: 6'd0
  };

  // Days in a month; February gains a day in years divisible by four.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      4'd2:                    days = leap ? 5'd29 : 5'd28;
      default:                 days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// ----- rtl/cte_step.sv -----
// Next edit copy and selection for one button event.
`timescale 1ns / 1ps

module cte_step (
  input  logic [2:0]         command,
  input  cte_pkg::cte_time_t load_time,
  input  logic [2:0]         cur_sel,
  input  cte_pkg::cte_time_t cur_time,
  output logic [2:0]         nxt_sel,
  output cte_pkg::cte_time_t nxt_time,
  output cte_pkg::cte_flags_t flags
);

  logic signed [5:0]  month_raw;
  logic signed [6:0]  date_raw;
  logic signed [13:0] year_raw;
  logic [11:0]        year_fix;
  logic [3:0]         month_fix;
  logic [4:0]         days;
  logic [4:0]         date_fix;
  logic [2:0]         sel_new;
  cte_pkg::cte_time_t work;

  always_comb begin
    sel_new   = cur_sel;
    work      = cur_time;
    month_raw = $signed({2'b00, cur_time.month});
    date_raw  = $signed({2'b00, cur_time.date});
    year_raw  = $signed({2'b00, cur_time.year});

    unique case (command)
      cte_pkg::CMD_LOAD: begin
        work      = load_time;
        month_raw = $signed({2'b00, load_time.month});
        date_raw  = $signed({2'b00, load_time.date});
        year_raw  = $signed({2'b00, load_time.year});
        sel_new   = cte_pkg::FIELD_WEEKDAY;
      end
      cte_pkg::CMD_NEXT: begin
        sel_new = (cur_sel < cte_pkg::FIELD_SECOND) ? cur_sel + 3'd1 : cte_pkg::FIELD_WEEKDAY;
      end
      cte_pkg::CMD_PREV: begin
        sel_new = (cur_sel > cte_pkg::FIELD_WEEKDAY) ? cur_sel - 3'd1 : cte_pkg::FIELD_SECOND;
      end
      cte_pkg::CMD_INC: begin
        case (cur_sel)
          cte_pkg::FIELD_WEEKDAY: work.weekday = (cur_time.weekday < cte_pkg::WEEKDAY_MAX) ?
                                    cur_time.weekday + 3'd1 : cte_pkg::WEEKDAY_MIN;
          cte_pkg::FIELD_MONTH:   month_raw = month_raw + 6'sd1;
          cte_pkg::FIELD_DATE:    date_raw  = date_raw + 7'sd1;
          cte_pkg::FIELD_YEAR:    year_raw  = year_raw + 14'sd1;
          cte_pkg::FIELD_HOUR:    work.hour = (cur_time.hour < cte_pkg::HOUR_MAX) ?
                                    cur_time.hour + 5'd1 : 5'd0;
          cte_pkg::FIELD_MINUTE:  work.minute = (cur_time.minute < cte_pkg::MINSEC_MAX) ?
                                    cur_time.minute + 6'd1 : 6'd0;
          cte_pkg::FIELD_SECOND:  work.second = (cur_time.second < cte_pkg::MINSEC_MAX) ?
                                    cur_time.second + 6'd1 : 6'd0;
          default: ;
        endcase
      end
      cte_pkg::CMD_DEC: begin
        case (cur_sel)
          cte_pkg::FIELD_WEEKDAY: work.weekday = (cur_time.weekday > cte_pkg::WEEKDAY_MIN) ?
                                    cur_time.weekday - 3'd1 : cte_pkg::WEEKDAY_MAX;
          cte_pkg::FIELD_MONTH:   month_raw = month_raw - 6'sd1;
          cte_pkg::FIELD_DATE:    date_raw  = date_raw - 7'sd1;
          cte_pkg::FIELD_YEAR:    year_raw  = year_raw - 14'sd1;
          cte_pkg::FIELD_HOUR:    work.hour = (cur_time.hour > 5'd0) ?
                                    cur_time.hour - 5'd1 : cte_pkg::HOUR_MAX;
          cte_pkg::FIELD_MINUTE:  work.minute = (cur_time.minute > 6'd0) ?
                                    cur_time.minute - 6'd1 : cte_pkg::MINSEC_MAX;
          cte_pkg::FIELD_SECOND:  work.second = (cur_time.second > 6'd0) ?
                                    cur_time.second - 6'd1 : cte_pkg::MINSEC_MAX;
          default: ;
        endcase
      end
      default: ;
    endcase

    // Range rules: year first, then month, then the date against the month length.
    if (year_raw > $signed({2'b00, cte_pkg::YEAR_MAX})) begin
      year_fix = cte_pkg::YEAR_MIN;
    end else if (year_raw < $signed({2'b00, cte_pkg::YEAR_MIN})) begin
      year_fix = cte_pkg::YEAR_MAX;
    end else begin
      year_fix = year_raw[11:0];
    end

    if (month_raw > $signed({2'b00, cte_pkg::MONTH_MAX})) begin
      month_fix = cte_pkg::MONTH_MIN;
    end else if (month_raw < $signed({2'b00, cte_pkg::MONTH_MIN})) begin
      month_fix = cte_pkg::MONTH_MAX;
    end else begin
      month_fix = month_raw[3:0];
    end

    days = cte_pkg::month_days(month_fix, year_fix[1:0] == 2'b00);

    // An overflowing date wraps only while the date itself is being edited.
    if (date_raw > $signed({2'b00, days})) begin
      date_fix = (sel_new == cte_pkg::FIELD_DATE) ? cte_pkg::DATE_MIN : days;
    end else if (date_raw < $signed({2'b00, cte_pkg::DATE_MIN})) begin
      date_fix = days;
    end else begin
      date_fix = date_raw[4:0];
    end

    flags.commit = (command == cte_pkg::CMD_COMMIT);
    flags.cancel = (command == cte_pkg::CMD_CANCEL);

    if (flags.commit || flags.cancel) begin
      nxt_sel  = cur_sel;
      nxt_time = cur_time;
    end else begin
      nxt_sel        = sel_new;
      nxt_time       = work;
      nxt_time.month = month_fix;
      nxt_time.date  = date_fix;
      nxt_time.year  = year_fix;
    end
  end

endmodule

// ----- rtl/calendar_time_field_editor_core.sv -----
// Top level of the calendar time field editor: input register, edit state, result register.
`timescale 1ns / 1ps

// Channel   Direction  tuser                          tdata
// s_axis    in         command[2:0]                   load weekday..second, 41 bits in 48
// m_axis    out        commit[0], cancel[1]           field, edit weekday..second, 44 in 48
//
// An accepted item is registered in the input register, then stepped against the edit state
// into the result register once that register is empty or being taken by the consumer.
// One item per cycle is sustained while m_axis_tready stays high: the input register refills
// while the result register drains.
// A stall on m_axis holds the result and the input register; s_axis_tready falls only when both hold.
// rst (synchronous) empties both registers and restores the edit state to 1900-01-01 00:00:00,
// weekday 1, field 0.

module calendar_time_field_editor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] weekday, [6:3] month, [11:7] date, [23:12] year, [28:24] hour,
  // [34:29] minute, [40:35] second, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] selected field, [5:3] weekday, [9:6] month, [14:10] date, [26:15] year,
  // [31:27] hour, [37:32] minute, [43:38] second, [47:44] zero
  output logic [47:0] m_axis_tdata,
  // [0] commit strobe, [1] cancel strobe
  output logic [1:0]  m_axis_tuser
);

  logic                in_valid;
  logic [2:0]          in_cmd;
  cte_pkg::cte_time_t  in_load;

  logic [2:0]          sel;
  cte_pkg::cte_time_t  edit_time;

  logic                out_valid;
  logic [2:0]          out_sel;
  cte_pkg::cte_time_t  out_time;
  cte_pkg::cte_flags_t out_flags;

  logic [2:0]          sel_next;
  cte_pkg::cte_time_t  edit_time_next;
  cte_pkg::cte_flags_t flags_next;

  logic                accept;
  logic                advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cte_step u_step (
    .command   (in_cmd),
    .load_time (in_load),
    .cur_sel   (sel),
    .cur_time  (edit_time),
    .nxt_sel   (sel_next),
    .nxt_time  (edit_time_next),
    .flags     (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd          <= s_axis_tuser;
      in_load.weekday <= s_axis_tdata[2:0];
      in_load.month   <= s_axis_tdata[6:3];
      in_load.date    <= s_axis_tdata[11:7];
      in_load.year    <= s_axis_tdata[23:12];
      in_load.hour    <= s_axis_tdata[28:24];
      in_load.minute  <= s_axis_tdata[34:29];
      in_load.second  <= s_axis_tdata[40:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= cte_pkg::FIELD_WEEKDAY;
      edit_time <= cte_pkg::RESET_TIME;
    end else if (advance) begin
      sel       <= sel_next;
      edit_time <= edit_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sel   <= sel_next;
      out_time  <= edit_time_next;
      out_flags <= flags_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_time.second, out_time.minute, out_time.hour,
                          out_time.year, out_time.date, out_time.month, out_time.weekday,
                          out_sel};
  assign m_axis_tuser  = {out_flags.cancel, out_flags.commit};

endmodule

// ----- rtl/cte_checker.sv -----
// Port-level checks of the calendar time field editor and their binding to the top level.
`timescale 1ns / 1ps
`include "calendar_time_field_editor_core_macros.svh"

module cte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A result held back by the consumer must not change under it.
  `CTE_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Commit and cancel come from different commands and never share an item.
  `CTE_ASSERT_NOW(a_one_strobe, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "commit and cancel together")

  // The selection cycles through the seven fields only.
  `CTE_ASSERT_NOW(a_sel_range, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7, "selected field out of range")

  // Month and date are always brought back into their ranges.
  `CTE_ASSERT_NOW(a_month_date, m_axis_tvalid, (m_axis_tdata[9:6] != 4'd0) && (m_axis_tdata[9:6] <= 4'd12) && (m_axis_tdata[14:10] != 5'd0), "month or date out of range")

  // The year stays within the two supported centuries.
  `CTE_ASSERT_NOW(a_year_range, m_axis_tvalid, (m_axis_tdata[26:15] >= 12'd1900) && (m_axis_tdata[26:15] <= 12'd2099), "year out of range")

endmodule

bind calendar_time_field_editor_core cte_checker u_cte_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
